>>> sv/datr_pkg.sv
// ----------------------------------------------------------------------------
// datr_pkg
// Shared types, widths and codes for the delivery acknowledge/timeout tracker.
// ----------------------------------------------------------------------------
package datr_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int SEQ_W       = 32;
    localparam int TIME_W      = 32;
    localparam int IN_DATA_W   = 72;
    localparam int OUT_DATA_W  = 40;

    localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd1000;

    // Request codes carried on the input tuser.
    localparam logic [1:0] REQ_SEND = 2'd0;
    localparam logic [1:0] REQ_ACK  = 2'd1;
    localparam logic [1:0] REQ_TICK = 2'd2;

    // Result codes carried on the output tuser.
    localparam logic [1:0] KIND_ASSIGNED  = 2'd0;
    localparam logic [1:0] KIND_FULL      = 2'd1;
    localparam logic [1:0] KIND_DELIVERED = 2'd2;
    localparam logic [1:0] KIND_TIMEOUT   = 2'd3;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;

    typedef struct packed {
        logic [SEQ_W-1:0]  number;
        logic [TIME_W-1:0] sent;
        logic              notify;
    } entry_t;

    // Table access requests; indexes are logical positions from the ring head.
    typedef struct packed {
        logic rd_en;
        idx_t rd_k;
        logic wr_en;
        idx_t wr_k;
    } tbl_ctrl_t;

    // Adds an offset to a ring position, wrapping at the table depth.
    function automatic idx_t ring_add(idx_t base, cnt_t off);
        logic [CNT_W:0] sum;
        sum = (CNT_W + 1)'(base) + (CNT_W + 1)'(off);
        if (sum >= (CNT_W + 1)'(TABLE_DEPTH))
        begin
            sum = sum - (CNT_W + 1)'(TABLE_DEPTH);
        end
        return idx_t'(sum);
    endfunction

endpackage

>>> sv/delivery_ack_timeout_tracker.sv
// ----------------------------------------------------------------------------
// delivery_ack_timeout_tracker
// Sender-side delivery tracker: assigns sequence numbers, retires entries on
// acknowledge and on timeout, and reports each retired entry newest first.
// ----------------------------------------------------------------------------
// m_tvalid rises from ST_FLUSH, which a send beat moves to, once the output is free,
// and the next input beat is taken after ST_FLUSH (later while the output stalls).
// An ack or tick beat reads the pending entries newest first, one per cycle through
// the single read port while no output stall holds the sweep: the next input beat
// follows once ST_SWEEP is done, and after ST_FLUSH as well when it reports.
// Reset empties the table at once, zeroes the sequence counter and sets timeout 1000.
module delivery_ack_timeout_tracker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [31:0]                      cfg_wr_data,  // timeout_ticks
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // now[31:0], ack_seq[63:32], notify[64]
    input  logic [datr_pkg::IN_DATA_W-1:0]   s_tdata,
    input  logic [1:0]                       s_tuser,      // req_type[1:0]
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [datr_pkg::OUT_DATA_W-1:0]  m_tdata,      // seq[31:0], wants_notice[32]
    output logic [1:0]                       m_tuser,      // kind[1:0]
    output logic                             m_tlast
);
    import datr_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SWEEP = 3'b010,
        ST_FLUSH = 3'b100
    } state_t;

    localparam cnt_t CNT_FULL = cnt_t'(TABLE_DEPTH);

    state_t            state_reg, state_next;
    cnt_t              count_reg, count_next;
    idx_t              head_reg, head_next;
    logic [SEQ_W-1:0]  next_number_reg, next_number_next;
    logic [TIME_W-1:0] timeout_reg, timeout_next;
    cnt_t              rem_reg, rem_next;
    cnt_t              hits_reg, hits_next;
    idx_t              wr_k_reg, wr_k_next;
    logic              st1_valid_reg, st1_valid_next;
    logic              held_valid_reg, held_valid_next;
    logic              m_tvalid_reg, m_tvalid_next;

    logic [1:0]        req_reg, req_next;
    logic [TIME_W-1:0] now_reg, now_next;
    logic [SEQ_W-1:0]  ack_reg, ack_next;
    logic [1:0]        held_kind_reg, held_kind_next;
    logic [SEQ_W-1:0]  held_seq_reg, held_seq_next;
    logic              held_notice_reg, held_notice_next;
    logic [1:0]        out_kind_reg, out_kind_next;
    logic [SEQ_W-1:0]  out_seq_reg, out_seq_next;
    logic              out_notice_reg, out_notice_next;
    logic              out_last_reg, out_last_next;

    tbl_ctrl_t         tbl_ctrl;
    entry_t            tbl_wr_data;
    entry_t            rd_data;

    logic [TIME_W-1:0] age;
    logic              hit;
    logic              out_free;
    logic              stall;
    logic [1:0]        sweep_kind;

    datr_table u_table (
        .clk     (clk),
        .head    (head_reg),
        .ctrl    (tbl_ctrl),
        .wr_data (tbl_wr_data),
        .rd_data (rd_data)
    );

    assign age        = now_reg - rd_data.sent;
    assign hit        = (req_reg == REQ_ACK) ? (rd_data.number == ack_reg)
                                             : (age >= timeout_reg);
    assign sweep_kind = (req_reg == REQ_ACK) ? KIND_DELIVERED : KIND_TIMEOUT;
    assign out_free   = !m_tvalid_reg || m_tready;
    // A hit needs the held report to move out first; wait if the output is full.
    assign stall      = st1_valid_reg && hit && held_valid_reg && !out_free;

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        head_next        = head_reg;
        next_number_next = next_number_reg;
        timeout_next     = timeout_reg;
        rem_next         = rem_reg;
        hits_next        = hits_reg;
        wr_k_next        = wr_k_reg;
        st1_valid_next   = st1_valid_reg;
        held_valid_next  = held_valid_reg;
        m_tvalid_next    = m_tvalid_reg;
        req_next         = req_reg;
        now_next         = now_reg;
        ack_next         = ack_reg;
        held_kind_next   = held_kind_reg;
        held_seq_next    = held_seq_reg;
        held_notice_next = held_notice_reg;
        out_kind_next    = out_kind_reg;
        out_seq_next     = out_seq_reg;
        out_notice_next  = out_notice_reg;
        out_last_next    = out_last_reg;
        tbl_ctrl         = '0;
        tbl_wr_data      = rd_data;

        if (cfg_wr_en)
        begin
            timeout_next = cfg_wr_data;
        end

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    req_next = s_tuser;
                    now_next = s_tdata[31:0];
                    ack_next = s_tdata[63:32];
                    case (s_tuser) inside
                        REQ_SEND:
                        begin
                            if (count_reg == CNT_FULL)
                            begin
                                held_kind_next   = KIND_FULL;
                                held_seq_next    = '0;
                                held_notice_next = 1'b0;
                            end
                            else
                            begin
                                tbl_ctrl.wr_en     = 1'b1;
                                tbl_ctrl.wr_k      = idx_t'(count_reg);
                                tbl_wr_data.number = next_number_reg;
                                tbl_wr_data.sent   = s_tdata[31:0];
                                tbl_wr_data.notify = s_tdata[64];
                                held_kind_next     = KIND_ASSIGNED;
                                held_seq_next      = next_number_reg;
                                held_notice_next   = s_tdata[64];
                                count_next         = count_reg + cnt_t'(1);
                                next_number_next   = next_number_reg + 32'd1;
                            end
                            held_valid_next = 1'b1;
                            state_next      = ST_FLUSH;
                        end
                        REQ_ACK, REQ_TICK:
                        begin
                            rem_next   = count_reg;
                            hits_next  = '0;
                            wr_k_next  = idx_t'(count_reg - cnt_t'(1));
                            state_next = ST_SWEEP;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SWEEP:
            begin
                if (!stall)
                begin
                    if (rem_reg != '0)
                    begin
                        tbl_ctrl.rd_en = 1'b1;
                        tbl_ctrl.rd_k  = idx_t'(rem_reg - cnt_t'(1));
                        rem_next       = rem_reg - cnt_t'(1);
                        st1_valid_next = 1'b1;
                    end
                    else
                    begin
                        st1_valid_next = 1'b0;
                    end

                    if (st1_valid_reg)
                    begin
                        if (hit)
                        begin
                            if (held_valid_reg)
                            begin
                                out_kind_next   = held_kind_reg;
                                out_seq_next    = held_seq_reg;
                                out_notice_next = held_notice_reg;
                                out_last_next   = 1'b0;
                                m_tvalid_next   = 1'b1;
                            end
                            held_kind_next   = sweep_kind;
                            held_seq_next    = rd_data.number;
                            held_notice_next = rd_data.notify;
                            held_valid_next  = 1'b1;
                            hits_next        = hits_reg + cnt_t'(1);
                        end
                        else
                        begin
                            // Survivors pack toward the newest end of the ring.
                            tbl_ctrl.wr_en = 1'b1;
                            tbl_ctrl.wr_k  = wr_k_reg;
                            wr_k_next      = wr_k_reg - idx_t'(1);
                        end
                    end
                    else if (rem_reg == '0)
                    begin
                        count_next = count_reg - hits_reg;
                        head_next  = ring_add(head_reg, hits_reg);
                        state_next = held_valid_reg ? ST_FLUSH : ST_IDLE;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (out_free)
                begin
                    out_kind_next   = held_kind_reg;
                    out_seq_next    = held_seq_reg;
                    out_notice_next = held_notice_reg;
                    out_last_next   = 1'b1;
                    m_tvalid_next   = 1'b1;
                    held_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            count_reg       <= '0;
            head_reg        <= '0;
            next_number_reg <= '0;
            timeout_reg     <= TIMEOUT_RESET;
            rem_reg         <= '0;
            hits_reg        <= '0;
            wr_k_reg        <= '0;
            st1_valid_reg   <= 1'b0;
            held_valid_reg  <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            count_reg       <= count_next;
            head_reg        <= head_next;
            next_number_reg <= next_number_next;
            timeout_reg     <= timeout_next;
            rem_reg         <= rem_next;
            hits_reg        <= hits_next;
            wr_k_reg        <= wr_k_next;
            st1_valid_reg   <= st1_valid_next;
            held_valid_reg  <= held_valid_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg         <= req_next;
        now_reg         <= now_next;
        ack_reg         <= ack_next;
        held_kind_reg   <= held_kind_next;
        held_seq_reg    <= held_seq_next;
        held_notice_reg <= held_notice_next;
        out_kind_reg    <= out_kind_next;
        out_seq_reg     <= out_seq_next;
        out_notice_reg  <= out_notice_next;
        out_last_reg    <= out_last_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'b0, out_notice_reg, out_seq_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

endmodule

>>> sv/datr_table.sv
// ----------------------------------------------------------------------------
// datr_table
// Pending-entry table: one synchronous memory organized as a ring, with one
// write and one registered read per cycle, both addressed from the ring head.
// ----------------------------------------------------------------------------
module datr_table (
    input  logic              clk,
    input  datr_pkg::idx_t    head,
    input  datr_pkg::tbl_ctrl_t ctrl,
    input  datr_pkg::entry_t  wr_data,
    output datr_pkg::entry_t  rd_data
);
    import datr_pkg::*;

    entry_t mem [TABLE_DEPTH];
    entry_t rd_q_reg;
    idx_t   wr_addr;
    idx_t   rd_addr;

    assign wr_addr = ring_add(head, cnt_t'(ctrl.wr_k));
    assign rd_addr = ring_add(head, cnt_t'(ctrl.rd_k));

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (ctrl.rd_en)
        begin
            rd_q_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_q_reg;

endmodule
